// ===== sv/lfid_pkg.sv =====
// ----------------------------------------------------------------------------
// lfid_pkg
// Shared types and constants of the lowest free id allocator.
// ----------------------------------------------------------------------------
package lfid_pkg;

    localparam int unsigned ID_CAPACITY = 1024;
    localparam int unsigned ID_W        = 10;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned OFS_W       = 5;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [ID_W-1:0] entity_id;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0] result_id;
        logic            success;
    } t_rsp;

endpackage

// ===== sv/lfid_find_zero.sv =====
// ----------------------------------------------------------------------------
// lfid_find_zero
// Priority encoder: index of the lowest clear bit of a vector.
// ----------------------------------------------------------------------------
module lfid_find_zero #(
    parameter int unsigned W = lfid_pkg::WORD_W
) (
    input  logic [W-1:0]                   i_vec,
    output logic [((W > 1) ? $clog2(W) : 1)-1:0] o_idx,
    output logic                           o_found
);

    localparam int unsigned IW = (W > 1) ? $clog2(W) : 1;

    always_comb begin
        o_idx   = '0;
        o_found = 1'b0;
        // scan from the top so the lowest clear bit wins
        for (int i = W - 1; i >= 0; i--) begin
            if (!i_vec[i]) begin
                o_idx   = IW'(i);
                o_found = 1'b1;
            end
        end
    end

endmodule

// ===== sv/lowest_free_id_allocator_top.sv =====
// ----------------------------------------------------------------------------
// lowest_free_id_allocator_top
// An allocate reads its summary word, then its leaf word, then registers its
// result; free and query register theirs after reading both words together,
// a failed allocate after checking the flop vector. A new request is taken
// only in the idle state, once the last response is registered; the dependent
// summary-then-leaf reads of the single-port bitmap memories set this pace.
// Reset: a clearing pass over the ceil(ID_CAPACITY/32) leaf words initializes
// the memories before the first input transfer.
// ----------------------------------------------------------------------------
// Live bitmap in 32-bit leaf words, a summary memory with one "word full" bit
// per leaf word, and a flop vector with one "summary word full" bit per summary word.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator_top #(
    parameter int unsigned ID_CAPACITY = lfid_pkg::ID_CAPACITY
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  lfid_pkg::t_req  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output lfid_pkg::t_rsp  o_out_data
);

    localparam int unsigned WW   = lfid_pkg::WORD_W;
    localparam int unsigned OW   = lfid_pkg::OFS_W;
    localparam int unsigned IDW  = lfid_pkg::ID_W;
    localparam int unsigned NW   = (ID_CAPACITY + WW - 1) / WW;
    localparam int unsigned NS   = (NW + WW - 1) / WW;
    localparam int unsigned LAW  = (NW > 1) ? $clog2(NW) : 1;
    localparam int unsigned SAW  = (NS > 1) ? $clog2(NS) : 1;
    localparam int unsigned FIDW = LAW + OW;
    localparam int unsigned XW   = FIDW + IDW;
    localparam int unsigned LREM = ID_CAPACITY - WW * (NW - 1);
    localparam int unsigned SREM = NW - WW * (NS - 1);
    localparam logic [63:0] LMASK = (64'd1 << LREM) - 64'd1;
    localparam logic [63:0] SMASK = (64'd1 << SREM) - 64'd1;
    // ids past capacity and leaf words past NW look permanently taken
    localparam logic [WW-1:0] LEAF_PAD = ~LMASK[WW-1:0];
    localparam logic [WW-1:0] SUM_PAD  = ~SMASK[WW-1:0];

    localparam logic [2:0] ST_CLR    = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_ASUM   = 3'd2;
    localparam logic [2:0] ST_ALEAF  = 3'd3;
    localparam logic [2:0] ST_FQ     = 3'd4;
    localparam logic [2:0] ST_NOFREE = 3'd5;

    logic [WW-1:0] r_leaf_mem [NW];
    logic [WW-1:0] r_sum_mem  [NS];

    logic [2:0]     r_state, n_state;
    logic [LAW-1:0] r_clr;
    logic [NS-1:0]  r_top;
    logic [1:0]     r_type;
    logic [IDW-1:0] r_id;
    logic           r_inr;
    logic [SAW-1:0] r_s;
    logic [OW-1:0]  r_w;
    logic [LAW-1:0] r_laddr;
    logic [WW-1:0]  r_leaf_q, r_sum_q;
    logic           r_ov;
    lfid_pkg::t_rsp r_out;

    logic           leaf_re, leaf_we, sum_re, sum_we;
    logic [LAW-1:0] leaf_raddr, leaf_waddr;
    logic [SAW-1:0] sum_raddr, sum_waddr;
    logic [WW-1:0]  leaf_wdata, sum_wdata;
    logic           top_set, top_clr;
    logic           done;
    lfid_pkg::t_rsp done_data;

    logic [SAW-1:0] top_idx;
    logic           top_found;
    logic [OW-1:0]  sum_idx;
    logic           sum_found;
    logic [OW-1:0]  bit_idx;
    logic           leaf_found;

    logic [XW-1:0]  in_ext;
    logic [LAW-1:0] in_laddr;
    logic [SAW-1:0] in_saddr;
    logic [OW-1:0]  in_sbit;
    logic           in_range;
    logic [LAW-1:0] alc_laddr;
    logic [WW-1:0]  leaf_set;
    logic [WW-1:0]  sum_set;
    logic [XW-1:0]  alc_ext;
    logic           live;
    logic           out_free;
    logic           accept;

    lfid_find_zero #(.W(NS)) u_top_find (
        .i_vec   (r_top),
        .o_idx   (top_idx),
        .o_found (top_found)
    );

    lfid_find_zero #(.W(WW)) u_sum_find (
        .i_vec   (r_sum_q),
        .o_idx   (sum_idx),
        .o_found (sum_found)
    );

    lfid_find_zero #(.W(WW)) u_leaf_find (
        .i_vec   (r_leaf_q),
        .o_idx   (bit_idx),
        .o_found (leaf_found)
    );

    assign in_ext    = XW'(i_in_data.entity_id);
    assign in_laddr  = in_ext[LAW+OW-1:OW];
    assign in_saddr  = in_ext[SAW+2*OW-1:2*OW];
    assign in_sbit   = in_ext[2*OW-1:OW];
    assign in_range  = 32'(i_in_data.entity_id) < 32'(ID_CAPACITY);
    assign alc_laddr = LAW'({r_s, sum_idx});
    assign leaf_set  = r_leaf_q | (WW'(1) << bit_idx);
    assign sum_set   = r_sum_q | (WW'(1) << r_w);
    assign alc_ext   = XW'({r_laddr, bit_idx});
    assign live      = r_inr && r_leaf_q[r_id[OW-1:0]];
    assign out_free  = !r_ov || i_out_ready;
    assign accept    = i_in_valid && (r_state == ST_IDLE);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_comb begin
        n_state    = r_state;
        leaf_re    = 1'b0;
        leaf_raddr = in_laddr;
        sum_re     = 1'b0;
        sum_raddr  = in_saddr;
        leaf_we    = 1'b0;
        leaf_waddr = r_laddr;
        leaf_wdata = '0;
        sum_we     = 1'b0;
        sum_waddr  = r_s;
        sum_wdata  = '0;
        top_set    = 1'b0;
        top_clr    = 1'b0;
        done       = 1'b0;
        done_data  = '0;
        case (r_state)
            ST_CLR: begin
                leaf_we    = 1'b1;
                leaf_waddr = r_clr;
                leaf_wdata = (32'(r_clr) == NW - 1) ? LEAF_PAD : '0;
                if (32'(r_clr) < NS) begin
                    sum_we    = 1'b1;
                    sum_waddr = r_clr[SAW-1:0];
                    sum_wdata = (32'(r_clr) == NS - 1) ? SUM_PAD : '0;
                end
                if (32'(r_clr) == NW - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.req_type == lfid_pkg::REQ_ALLOC) begin
                        if (top_found) begin
                            sum_re    = 1'b1;
                            sum_raddr = top_idx;
                            n_state   = ST_ASUM;
                        end else begin
                            n_state = ST_NOFREE;
                        end
                    end else begin
                        leaf_re = 1'b1;
                        sum_re  = 1'b1;
                        n_state = ST_FQ;
                    end
                end
            end
            ST_ASUM: begin
                leaf_re    = sum_found;
                leaf_raddr = alc_laddr;
                n_state    = ST_ALEAF;
            end
            ST_ALEAF: begin
                if (out_free) begin
                    done                = 1'b1;
                    done_data.result_id = alc_ext[IDW-1:0];
                    done_data.success   = leaf_found;
                    leaf_we             = 1'b1;
                    leaf_wdata          = leaf_set;
                    if (&leaf_set) begin
                        sum_we    = 1'b1;
                        sum_wdata = sum_set;
                        top_set   = &sum_set;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_FQ: begin
                if (out_free) begin
                    done                = 1'b1;
                    done_data.result_id = r_id;
                    done_data.success   = live && ((r_type == lfid_pkg::REQ_FREE) ||
                                                   (r_type == lfid_pkg::REQ_QUERY));
                    if (live && (r_type == lfid_pkg::REQ_FREE)) begin
                        leaf_we    = 1'b1;
                        leaf_wdata = r_leaf_q & ~(WW'(1) << r_id[OW-1:0]);
                        sum_we     = 1'b1;
                        sum_wdata  = r_sum_q & ~(WW'(1) << r_w);
                        top_clr    = 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_NOFREE: begin
                if (out_free) begin
                    done    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr   <= '0;
            r_top   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLR) begin
                r_clr <= r_clr + LAW'(1);
            end
            if (top_set) begin
                r_top[r_s] <= 1'b1;
            end else if (top_clr) begin
                r_top[r_s] <= 1'b0;
            end
            if (done) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // request context
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_type  <= i_in_data.req_type;
            r_id    <= i_in_data.entity_id;
            r_inr   <= in_range;
            r_laddr <= in_laddr;
            r_w     <= in_sbit;
            r_s     <= (i_in_data.req_type == lfid_pkg::REQ_ALLOC) ? top_idx : in_saddr;
        end else if (r_state == ST_ASUM) begin
            r_laddr <= alc_laddr;
            r_w     <= sum_idx;
        end
        if (done) begin
            r_out <= done_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (leaf_we) begin
            r_leaf_mem[leaf_waddr] <= leaf_wdata;
        end
        if (leaf_re) begin
            r_leaf_q <= r_leaf_mem[leaf_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            r_sum_mem[sum_waddr] <= sum_wdata;
        end
        if (sum_re) begin
            r_sum_q <= r_sum_mem[sum_raddr];
        end
    end

endmodule

// ===== dv/tb_lowest_free_id_allocator_top.sv =====
// ----------------------------------------------------------------------------
// tb_lowest_free_id_allocator_top
// Self-checking bench for the id allocator. A queue of requests (a directed
// opening, then mixed, pool-filling and near-capacity traffic) feeds a
// valid/ready driver. A monitor keeps a shadow live map and high-water mark,
// works out each response at input transfer and compares responses in order.
// ----------------------------------------------------------------------------
module tb_lowest_free_id_allocator_top;

    localparam int unsigned ID_CAPACITY = lfid_pkg::ID_CAPACITY;
    localparam int unsigned ID_W        = lfid_pkg::ID_W;
    localparam logic [1:0]  REQ_UNUSED = 2'd3;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned HOLD_AFTER  = 700;
    localparam int unsigned SETTLE_CYC  = 8;

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    logic           i_out_ready = 1'b0;
    lfid_pkg::t_req i_in_data   = '0;
    logic           o_in_ready;
    logic           o_out_valid;
    lfid_pkg::t_rsp o_out_data;

    lowest_free_id_allocator_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // shadow of the allocator state
    logic [ID_CAPACITY-1:0] shadow_live = '0;
    int unsigned            shadow_fresh = 0;

    lfid_pkg::t_req pending_reqs[$];
    lfid_pkg::t_rsp expected_rsps[$];

    int unsigned n_errors     = 0;
    int unsigned n_out_xfers  = 0;
    int unsigned n_alloc_ok   = 0;
    int unsigned n_alloc_full = 0;
    int unsigned n_free_hit   = 0;
    int unsigned n_query_hit  = 0;
    int unsigned n_noise      = 0;

    logic        quiet_phase = 1'b0;
    int unsigned cycle_cnt   = 0;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Updates the shadow state and returns the response the block must give.
    function automatic lfid_pkg::t_rsp apply_request(lfid_pkg::t_req req);
        lfid_pkg::t_rsp rsp;
        int unsigned    id;
        int unsigned    slot;
        logic           found;
        id            = 32'(req.entity_id);
        rsp.result_id = req.entity_id;
        rsp.success   = 1'b0;
        found         = 1'b0;
        case (req.req_type)
            lfid_pkg::REQ_ALLOC: begin
                rsp.result_id = '0;
                for (slot = 0; slot < shadow_fresh && slot < ID_CAPACITY; slot++) begin
                    if (!shadow_live[slot]) begin
                        found = 1'b1;
                        break;
                    end
                end
                if (found) begin
                    shadow_live[slot] = 1'b1;
                    rsp.result_id     = ID_W'(slot);
                    rsp.success       = 1'b1;
                end else if (shadow_fresh < ID_CAPACITY) begin
                    shadow_live[shadow_fresh] = 1'b1;
                    rsp.result_id             = ID_W'(shadow_fresh);
                    rsp.success               = 1'b1;
                    shadow_fresh++;
                end
                if (rsp.success) n_alloc_ok++;
                else n_alloc_full++;
            end
            lfid_pkg::REQ_FREE: begin
                if (id < ID_CAPACITY && shadow_live[id]) begin
                    shadow_live[id] = 1'b0;
                    rsp.success     = 1'b1;
                    n_free_hit++;
                end
            end
            lfid_pkg::REQ_QUERY: begin
                rsp.success = id < ID_CAPACITY && shadow_live[id];
                if (rsp.success) n_query_hit++;
            end
            default: n_noise++;
        endcase
        return rsp;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("MISMATCH %s: got %0d, expected %0d (response %0d)",
                 what, got, want, n_out_xfers);
        n_errors++;
    endtask

    task automatic add_req(logic [1:0] kind, int unsigned id);
        lfid_pkg::t_req req;
        req.req_type  = kind;
        req.entity_id = ID_W'(id);
        pending_reqs  = {pending_reqs, req};
    endtask

    // alternate stretches with and without idling on both sides
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt % 512 == 511) begin
            quiet_phase <= ($urandom_range(0, 3) == 0);
        end
    end

    // request driver
    int unsigned send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (send_gap != 0) begin
                i_in_valid <= 1'b0;
                send_gap   <= send_gap - 1;
            end else if (pending_reqs.size() != 0) begin
                i_in_data  <= pending_reqs.pop_front();
                i_in_valid <= 1'b1;
                send_gap   <= quiet_phase ? 0 : pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // response sink, with one long hold-off to back the block up
    int unsigned stall_left    = 0;
    int unsigned hold_left     = 0;
    logic        pressure_done = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else if (!pressure_done && n_out_xfers >= HOLD_AFTER) begin
            pressure_done <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            i_out_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            stall_left  <= quiet_phase ? 0 : pick_gap();
        end
    end

    // monitor: predict on input transfer, check responses in order
    always @(posedge i_clk) begin : mon
        lfid_pkg::t_rsp want;
        lfid_pkg::t_rsp pred;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                pred          = apply_request(i_in_data);
                expected_rsps = {expected_rsps, pred};
            end
            if (o_out_valid && i_out_ready) begin
                n_out_xfers <= n_out_xfers + 1;
                if (expected_rsps.size() == 0) begin
                    report_mismatch("unexpected response, result_id",
                                    32'(o_out_data.result_id), 0);
                end else begin
                    want = expected_rsps.pop_front();
                    if (o_out_data.result_id !== want.result_id)
                        report_mismatch("result_id", 32'(o_out_data.result_id),
                                        32'(want.result_id));
                    if (o_out_data.success !== want.success)
                        report_mismatch("success", 32'(o_out_data.success),
                                        32'(want.success));
                end
            end
        end
    end

    int unsigned idle_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("lowest_free_id_allocator_top verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stim
        int unsigned issued;
        int unsigned r;
        int unsigned i;
        issued = 0;

        // directed opening
        add_req(lfid_pkg::REQ_ALLOC, 0);
        add_req(lfid_pkg::REQ_ALLOC, 1023);
        add_req(lfid_pkg::REQ_ALLOC, 0);
        add_req(lfid_pkg::REQ_QUERY, 1);
        add_req(lfid_pkg::REQ_FREE, 1);
        add_req(lfid_pkg::REQ_FREE, 1);          // already free
        add_req(lfid_pkg::REQ_QUERY, 1);
        add_req(lfid_pkg::REQ_ALLOC, 0);         // reuses the hole
        add_req(lfid_pkg::REQ_FREE, 0);
        add_req(lfid_pkg::REQ_FREE, 2);
        add_req(lfid_pkg::REQ_ALLOC, 0);
        add_req(lfid_pkg::REQ_ALLOC, 0);
        add_req(lfid_pkg::REQ_ALLOC, 0);         // fresh again
        add_req(lfid_pkg::REQ_QUERY, 1023);      // never handed out
        add_req(lfid_pkg::REQ_FREE, 1023);
        add_req(REQ_UNUSED, 1023);
        add_req(REQ_UNUSED, 'h155);
        add_req(lfid_pkg::REQ_QUERY, 'h2AA);
        add_req(lfid_pkg::REQ_FREE, 'h155);
        add_req(lfid_pkg::REQ_QUERY, 0);
        add_req(lfid_pkg::REQ_QUERY, 3);
        issued = 6;

        // mixed traffic over the handed-out range
        for (i = 0; i < 500; i++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                add_req(lfid_pkg::REQ_ALLOC, $urandom_range(0, 1023));
                issued++;
            end else if (r < 75) begin
                add_req(lfid_pkg::REQ_FREE,
                        $urandom_range(0, issued < 1023 ? issued : 1023));
            end else if (r < 93) begin
                add_req(lfid_pkg::REQ_QUERY,
                        $urandom_range(0, issued < 1023 ? issued : 1023));
            end else if (r < 97) begin
                add_req($urandom_range(0, 1) ? lfid_pkg::REQ_FREE : lfid_pkg::REQ_QUERY,
                        $urandom_range(0, 1023));
            end else begin
                add_req(REQ_UNUSED, $urandom_range(0, 1023));
            end
        end

        // fill the pool past capacity so allocations get refused
        for (i = 0; i < 1100; i++) begin
            if ($urandom_range(0, 99) < 95)
                add_req(lfid_pkg::REQ_ALLOC, $urandom_range(0, 1023));
            else
                add_req(lfid_pkg::REQ_QUERY, $urandom_range(0, 1023));
        end

        // churn near capacity: holes anywhere, refills, refusals
        for (i = 0; i < 400; i++) begin
            r = $urandom_range(0, 99);
            if (r < 35) add_req(lfid_pkg::REQ_FREE, $urandom_range(0, 1023));
            else if (r < 75) add_req(lfid_pkg::REQ_ALLOC, $urandom_range(0, 1023));
            else if (r < 95) add_req(lfid_pkg::REQ_QUERY, $urandom_range(0, 1023));
            else add_req(REQ_UNUSED, $urandom_range(0, 1023));
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || i_in_valid || expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("run covered %0d responses: %0d allocations granted, %0d refused when full",
                 n_out_xfers, n_alloc_ok, n_alloc_full);
        $display("frees of live ids %0d, queries hitting live ids %0d, unused codes %0d",
                 n_free_hit, n_query_hit, n_noise);
        if (n_errors == 0) begin
            $display("lowest_free_id_allocator_top verification clean");
        end else begin
            $display("lowest_free_id_allocator_top verification failed");
        end
        $finish;
    end

endmodule
